// ----- hw/rtl/text_terminal_engine_assert.svh -----
// Assertion macros shared by the text terminal engine RTL.
`ifndef TEXT_TERMINAL_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text terminal engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text terminal engine check failed");

`endif

// ----- hw/rtl/tte_pkg.sv -----
// Shared types and constants of the text terminal engine.
`default_nettype none

package tte_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_BACKSPACE = 2'd1,
        ACT_CLEAR     = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       to_line_end;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_index;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/tte_ifs.sv -----
// Valid/ready channel interfaces of the text terminal engine.
`default_nettype none

interface tte_in_if import tte_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tte_out_if import tte_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tte_cfg_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/text_terminal_engine.sv -----
// Text terminal engine: screen memory, cursor and the sequencer around them.
// One item is in flight at a time; input is taken only in the idle state.
// After reset a clearing pass blanks the screen before input opens.
// The attribute register takes a transfer in every cycle and resets to 07.
`default_nettype none
`include "text_terminal_engine_assert.svh"

module text_terminal_engine import tte_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tte_in_if.sink      i_in,
    tte_out_if.source   o_out,
    tte_cfg_if.sink     i_cfg
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [8:0] {
        S_CLR     = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_PUT     = 9'b000000100,
        S_SCR_RD  = 9'b000001000,
        S_SCR_WR  = 9'b000010000,
        S_SCAN_RD = 9'b000100000,
        S_SCAN_CK = 9'b001000000,
        S_RDGET   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_scan, n_scan;
    logic            r_init, n_init;
    logic            r_ret_put, n_ret_put;
    logic            r_scrolled, n_scrolled;
    logic            r_rd_ok, n_rd_ok;
    t_action         r_act, n_act;
    logic [7:0]      r_code, n_code;
    logic [7:0]      r_rchar, n_rchar;
    logic [7:0]      r_rattr, n_rattr;
    logic [7:0]      r_attr;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [15:0]     r_mem [CELLS];
    logic [15:0]     r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     mem_wdata;

    logic            in_acc;
    logic            ld_out;
    logic [31:0]     cur_lin;
    logic [AW-1:0]   cur_addr;
    logic [31:0]     col32;
    logic [31:0]     row32;
    logic [31:0]     rd_lin;
    logic [31:0]     scan_lin;
    logic [7:0]      put_char;
    t_action         in_act;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign in_act      = t_action'(i_in.data.action);
    assign i_cfg.ready = 1'b1;

    assign col32    = 32'(r_col);
    assign row32    = 32'(r_row);
    assign cur_lin  = row32 * COLUMNS + col32;
    assign cur_addr = cur_lin[AW-1:0];
    assign rd_lin   = 32'(i_in.data.read_row) * COLUMNS + 32'(i_in.data.read_col);
    assign scan_lin = row32 * COLUMNS + 32'(r_scan) - 32'd1;
    assign put_char = (r_act == ACT_WRITE) ? r_code : SPACE_CODE;

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_ptr      = r_ptr;
        n_scan     = r_scan;
        n_init     = r_init;
        n_ret_put  = r_ret_put;
        n_scrolled = r_scrolled;
        n_rd_ok    = r_rd_ok;
        n_act      = r_act;
        n_code     = r_code;
        n_rchar    = r_rchar;
        n_rattr    = r_rattr;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = {r_attr, SPACE_CODE};
        mem_raddr  = cur_addr;
        ld_out     = 1'b0;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = {(r_init ? RESET_ATTR : r_attr), SPACE_CODE};
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_init = 1'b0;
                    if (r_init) begin
                        n_state = S_IDLE;
                    end else if (r_ret_put) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                mem_raddr = rd_lin[AW-1:0];
                if (in_acc) begin
                    n_act      = in_act;
                    n_code     = i_in.data.char_code;
                    n_scrolled = 1'b0;
                    n_rchar    = '0;
                    n_rattr    = '0;
                    n_ret_put  = 1'b0;
                    n_ptr      = '0;
                    unique case (in_act)
                        ACT_WRITE: begin
                            if (i_in.data.char_code == NEWLINE_CODE || col32 >= COLUMNS) begin
                                // Newline, or a write that must wrap before it stores.
                                n_col     = '0;
                                n_ret_put = (i_in.data.char_code != NEWLINE_CODE);
                                if (r_row == RW'(ROWS - 1)) begin
                                    n_scrolled = 1'b1;
                                    n_state    = S_SCR_RD;
                                end else begin
                                    n_row   = r_row + RW'(1);
                                    n_state = n_ret_put ? S_PUT : S_DONE;
                                end
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        ACT_BACKSPACE: begin
                            if (r_col == '0 && r_row == '0) begin
                                n_state = S_DONE;
                            end else if (r_col == '0 && i_in.data.to_line_end) begin
                                n_row   = r_row - RW'(1);
                                n_scan  = CW'(COLUMNS);
                                n_state = S_SCAN_RD;
                            end else begin
                                if (r_col == '0) begin
                                    n_row = r_row - RW'(1);
                                    n_col = CW'(COLUMNS - 1);
                                end else begin
                                    n_col = r_col - CW'(1);
                                end
                                n_state = S_PUT;
                            end
                        end
                        ACT_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_state = S_CLR;
                        end
                        ACT_READ: begin
                            n_rd_ok = (32'(i_in.data.read_col) < COLUMNS) &&
                                      (32'(i_in.data.read_row) < ROWS);
                            n_state = S_RDGET;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = {r_attr, put_char};
                n_ret_put = 1'b0;
                if (r_act == ACT_WRITE) begin
                    if (col32 + 32'd1 >= COLUMNS) begin
                        n_col = '0;
                        if (r_row == RW'(ROWS - 1)) begin
                            n_scrolled = 1'b1;
                            n_ptr      = '0;
                            n_state    = S_SCR_RD;
                        end else begin
                            n_row   = r_row + RW'(1);
                            n_state = S_DONE;
                        end
                    end else begin
                        n_col   = r_col + CW'(1);
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCR_RD: begin
                mem_raddr = r_ptr + AW'(COLUMNS);
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_rdata;
                n_ptr     = r_ptr + AW'(1);
                // The copy ends one row short; the fill pass blanks the last row.
                n_state   = (r_ptr == AW'(CELLS - COLUMNS - 1)) ? S_CLR : S_SCR_RD;
            end
            S_SCAN_RD: begin
                mem_raddr = scan_lin[AW-1:0];
                n_state   = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (r_rdata[7:0] != SPACE_CODE) begin
                    n_col   = r_scan;
                    n_state = S_DONE;
                end else if (r_scan == CW'(1)) begin
                    n_col   = '0;
                    n_state = S_DONE;
                end else begin
                    n_scan  = r_scan - CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_RDGET: begin
                if (r_rd_ok) begin
                    n_rchar = r_rdata[7:0];
                    n_rattr = r_rdata[15:8];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_ret_put   <= 1'b0;
            r_out_valid <= 1'b0;
            r_attr      <= RESET_ATTR;
        end else begin
            r_state   <= n_state;
            r_init    <= n_init;
            r_ptr     <= n_ptr;
            r_col     <= n_col;
            r_row     <= n_row;
            r_ret_put <= n_ret_put;
            if (i_cfg.valid) begin
                r_attr <= i_cfg.data;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_scrolled <= n_scrolled;
        r_rd_ok    <= n_rd_ok;
        r_act      <= n_act;
        r_code     <= n_code;
        r_rchar    <= n_rchar;
        r_rattr    <= n_rattr;
        if (ld_out) begin
            r_out.cursor_col   <= col32[6:0];
            r_out.cursor_row   <= row32[4:0];
            r_out.cursor_index <= cur_lin[10:0];
            r_out.cell_char    <= r_rchar;
            r_out.cell_attr    <= r_rattr;
            r_out.scrolled     <= r_scrolled;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `TTE_ASSERT_IMPL(a_cursor_range, i_clk, i_rst_n, 1'b1,
        r_col <= CW'(COLUMNS) && r_row <= RW'(ROWS - 1))
    `TTE_ASSERT_IMPL(a_put_in_row, i_clk, i_rst_n, r_state == S_PUT, col32 < COLUMNS)
    `TTE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `TTE_ASSERT_IMPL(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !mem_we)
    `TTE_ASSERT_NEXT(a_done_waits, i_clk, i_rst_n,
        r_state == S_DONE && r_out_valid && !o_out.ready, r_state == S_DONE)

endmodule

`default_nettype wire
